/* rtl/pcm_voice_mixer_with_tone_unit_assert.svh */
// Assertion macros for the voice mixer
`ifndef PCM_VOICE_MIXER_WITH_TONE_UNIT_ASSERT_SVH
`define PCM_VOICE_MIXER_WITH_TONE_UNIT_ASSERT_SVH
// implication checked on every clock outside reset
`define PVM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define PVM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

/* rtl/pvm_pkg.sv */
package pvm_pkg;
  localparam int VOICES      = 8;
  localparam int STORE_DEPTH = 65536;
  localparam int VW          = $clog2(VOICES);
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int LW          = 17;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_WRITE   = 3'd1;
  localparam logic [2:0] OP_PREPARE = 3'd2;
  localparam logic [2:0] OP_PLAY    = 3'd3;
  localparam logic [2:0] OP_STOP    = 3'd4;
  localparam logic [2:0] OP_RELEASE = 3'd5;

  localparam logic [1:0] REG_VOLUME    = 2'd0;
  localparam logic [1:0] REG_TONE_STEP = 2'd1;
  localparam logic [1:0] REG_TONE_AMP  = 2'd2;
  localparam logic [1:0] REG_TONE_EN   = 2'd3;

  // controller commands to the datapath
  typedef struct packed {
    logic          cmd_op;     // apply non-tick operation
    logic          tick_start; // clear accumulator, step tone if enabled
    logic          rd_issue;   // issue store read for voice rd_voice
    logic [VW-1:0] rd_voice;
    logic          acc_en;     // accumulate/advance voice acc_voice
    logic [VW-1:0] acc_voice;
    logic          mul_en;     // register product
    logic          duty_en;    // clamp and store duty
  } pvm_cmd_t;
endpackage

/* rtl/pvm_ctrl.sv */
module pvm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        op,
  output logic              out_valid,
  input  logic              out_ready,
  output pvm_pkg::pvm_cmd_t cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DUTY = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [pvm_pkg::VW:0]  cnt_r, cnt_nxt;
  logic                  accept;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (op == pvm_pkg::OP_TICK) begin
            cmd.tick_start = 1'b1;
            state_nxt      = S_RD;
            cnt_nxt        = '0;
          end else begin
            cmd.cmd_op = 1'b1;
            state_nxt  = S_OUT;
          end
        end
      end
      // issue read for cnt, accumulate cnt-1 whose data is now registered
      S_RD: begin
        cmd.rd_issue  = (cnt_r < (pvm_pkg::VW+1)'(pvm_pkg::VOICES));
        cmd.rd_voice  = cnt_r[pvm_pkg::VW-1:0];
        cmd.acc_en    = (cnt_r != '0);
        cmd.acc_voice = pvm_pkg::VW'(cnt_r - 1'b1);
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == (pvm_pkg::VW+1)'(pvm_pkg::VOICES)) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_DUTY;
      end
      S_DUTY: begin
        cmd.duty_en = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end
endmodule

/* rtl/pvm_datapath.sv */
module pvm_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pvm_pkg::pvm_cmd_t      cmd,
  input  logic [2:0]             op,
  input  logic [2:0]             voice,
  input  logic [15:0]            address,
  input  logic [7:0]             sample_byte,
  input  logic [16:0]            length,
  input  logic                   loop_mode,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  output logic [7:0]             pwm_duty,
  output logic [7:0]             playing_mask
);
  localparam int NV = pvm_pkg::VOICES;
  localparam int LW = pvm_pkg::LW;

  logic [7:0]    store_mem [pvm_pkg::STORE_DEPTH];
  logic [7:0]    rd_data_r;

  logic [15:0]   start_r  [NV];
  logic [LW-1:0] len_r    [NV];
  logic [15:0]   addr_r   [NV];
  logic [LW-1:0] rem_r    [NV];
  logic [NV-1:0] prep_r, play_r, loop_r;

  logic [3:0]    volume_r;
  logic [15:0]   tone_step_r, phase_r;
  logic [6:0]    tone_amp_r;
  logic          tone_en_r;

  logic signed [11:0] acc_r;
  logic signed [16:0] prod_r;
  logic [7:0]         duty_r;

  logic               vok;
  logic [pvm_pkg::VW-1:0] vi, av;
  logic [LW-1:0]      rem_dec;
  logic signed [7:0]  smp;
  logic signed [11:0] mix;
  logic signed [16:0] clamped;
  logic [15:0]        phase_nxt;

  assign vi  = voice[pvm_pkg::VW-1:0];
  assign vok = ({1'b0, voice} < 4'(NV));
  assign av  = cmd.acc_voice;
  assign rem_dec = rem_r[av] - 1'b1;
  // byte minus 127, wrapped to 8 bits
  assign smp = signed'(8'(rd_data_r - 8'd127));
  assign phase_nxt = phase_r + tone_step_r;

  // sample store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.cmd_op && op == pvm_pkg::OP_WRITE)
      store_mem[address[pvm_pkg::AW-1:0]] <= sample_byte;
    if (cmd.rd_issue)
      rd_data_r <= store_mem[addr_r[cmd.rd_voice][pvm_pkg::AW-1:0]];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r    <= 4'd2;
      tone_step_r <= '0;
      tone_amp_r  <= 7'd8;
      tone_en_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pvm_pkg::REG_VOLUME:    volume_r    <= cfg_data[3:0];
        pvm_pkg::REG_TONE_STEP: tone_step_r <= cfg_data;
        pvm_pkg::REG_TONE_AMP:  tone_amp_r  <= cfg_data[6:0];
        pvm_pkg::REG_TONE_EN:   tone_en_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // voice state, commands and per-voice advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NV; i++) begin
        start_r[i] <= '0;
        len_r[i]   <= '0;
        addr_r[i]  <= '0;
        rem_r[i]   <= '0;
      end
      prep_r <= '0;
      play_r <= '0;
      loop_r <= '0;
    end else if (cmd.cmd_op && vok) begin
      case (op)
        pvm_pkg::OP_PREPARE: begin
          start_r[vi] <= address;
          len_r[vi]   <= length;
          addr_r[vi]  <= address;
          rem_r[vi]   <= length;
          prep_r[vi]  <= 1'b1;
        end
        pvm_pkg::OP_PLAY: begin
          if (prep_r[vi]) begin
            addr_r[vi] <= start_r[vi];
            rem_r[vi]  <= len_r[vi];
            play_r[vi] <= 1'b1;
            loop_r[vi] <= loop_mode;
          end
        end
        pvm_pkg::OP_STOP: play_r[vi] <= 1'b0;
        pvm_pkg::OP_RELEASE: begin
          prep_r[vi] <= 1'b0;
          play_r[vi] <= 1'b0;
        end
        default: ;
      endcase
    end else if (cmd.acc_en && play_r[av]) begin
      if (rem_dec == '0) begin
        if (loop_r[av]) begin
          addr_r[av] <= start_r[av];
          rem_r[av]  <= len_r[av];
        end else begin
          addr_r[av] <= addr_r[av] + 1'b1;
          rem_r[av]  <= rem_dec;
          play_r[av] <= 1'b0;
        end
      end else begin
        addr_r[av] <= addr_r[av] + 1'b1;
        rem_r[av]  <= rem_dec;
      end
    end
  end

  // tone, accumulate, scale, clamp
  always_comb begin
    mix = acc_r;
    if (tone_en_r) begin
      if (phase_r[15]) mix = acc_r + 12'(signed'({4'b0, tone_amp_r, 1'b0}));
      else             mix = acc_r - 12'(signed'({4'b0, tone_amp_r, 1'b0}));
    end
    clamped = prod_r;
    if (prod_r > 17'sd127)  clamped = 17'sd127;
    if (prod_r < -17'sd127) clamped = -17'sd127;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      duty_r  <= 8'd127;
      acc_r   <= '0;
    end else begin
      if (cmd.tick_start) begin
        acc_r <= '0;
        if (tone_en_r) phase_r <= phase_nxt;
      end else if (cmd.acc_en && play_r[av]) begin
        acc_r <= acc_r + 12'(smp);
      end
      if (cmd.duty_en) duty_r <= 8'(clamped + 17'sd127);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= 17'(mix) * signed'({13'b0, volume_r});
  end

  assign pwm_duty     = duty_r;
  assign playing_mask = 8'(play_r);
endmodule

/* rtl/pcm_voice_mixer_with_tone_unit.sv */
// Eight-voice PCM sample player with square tone, one result item per input item.
// A non-tick operation presents its result in the cycle after accept. A tick
// first reads the voices through the sample store's single read port, one per
// cycle (nine read/accumulate steps), then runs one multiply and one clamp stage.
// One item is in flight at a time; the result waits in the output register until
// taken.
`include "pcm_voice_mixer_with_tone_unit_assert.svh"
module pcm_voice_mixer_with_tone_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [2:0]  in_voice,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_sample_byte,
  input  logic [16:0] in_length,
  input  logic        in_loop_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_pwm_duty,
  output logic [7:0]  out_playing_mask,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  pvm_pkg::pvm_cmd_t cmd;

  pvm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .op(in_operation),
    .out_valid, .out_ready, .cmd
  );

  pvm_datapath u_dp (
    .clk, .rst_n, .cmd, .op(in_operation), .voice(in_voice),
    .address(in_address), .sample_byte(in_sample_byte), .length(in_length),
    .loop_mode(in_loop_mode), .cfg_we, .cfg_index, .cfg_data,
    .pwm_duty(out_pwm_duty), .playing_mask(out_playing_mask)
  );

  `PVM_ASSERT_IMP(a_no_overlap, in_ready, !out_valid, "ready while result pending")
  `PVM_ASSERT_NXT(a_out_after, out_valid && out_ready, in_ready, "no return to idle")
  `PVM_ASSERT_IMP(a_duty_range, 1'b1, out_pwm_duty <= 8'd254, "duty out of range")
endmodule

/* test/pcm_voice_mixer_with_tone_unit_test.sv */
`timescale 1ns / 100ps

module pcm_voice_mixer_with_tone_unit_test;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  voice;
    logic [15:0] addr;
    logic [7:0]  sbyte;
    logic [16:0] len;
    logic        loop_m;
  } mix_item_t;

  typedef struct packed {
    logic [7:0] duty;
    logic [7:0] mask;
  } mix_out_t;

  typedef struct {
    bit [7:0]  store[pvm_pkg::STORE_DEPTH];
    bit [15:0] start_a[pvm_pkg::VOICES];
    bit [15:0] addr_a[pvm_pkg::VOICES];
    bit [16:0] len_a[pvm_pkg::VOICES];
    bit [16:0] rem_a[pvm_pkg::VOICES];
    bit        prepared[pvm_pkg::VOICES];
    bit        playing[pvm_pkg::VOICES];
    bit        looping[pvm_pkg::VOICES];
    bit [15:0] phase;
    bit [7:0]  duty;
    bit [3:0]  volume;
    bit [15:0] step;
    bit [6:0]  amp;
    bit        tone_en;
  } mix_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_operation = '0;
  logic [2:0]  in_voice = '0;
  logic [15:0] in_address = '0;
  logic [7:0]  in_sample_byte = '0;
  logic [16:0] in_length = '0;
  logic        in_loop_mode = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_pwm_duty;
  logic [7:0]  out_playing_mask;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  mix_state_t plan_st;   // generator copy, runs ahead of the block
  mix_state_t pred_st;   // predictor copy, advanced on each accepted item
  bit         written[pvm_pkg::STORE_DEPTH];
  mix_item_t  pending_items[$];
  mix_out_t   expected_outs[$];
  bit         failed = 1'b0;

  pcm_voice_mixer_with_tone_unit u_dut (.*);

  always #6 clk = ~clk;

  function automatic void mixer_reset(ref mix_state_t s);
    foreach (s.store[i]) s.store[i] = '0;
    for (int v = 0; v < pvm_pkg::VOICES; v++) begin
      s.start_a[v] = '0; s.addr_a[v] = '0; s.len_a[v] = '0; s.rem_a[v] = '0;
      s.prepared[v] = 0; s.playing[v] = 0; s.looping[v] = 0;
    end
    s.phase = '0; s.duty = 8'd127;
    s.volume = 4'd2; s.step = '0; s.amp = 7'd8; s.tone_en = 0;
  endfunction

  function automatic void mixer_config(ref mix_state_t s, input logic [1:0] idx,
                                       input logic [15:0] val);
    case (idx)
      pvm_pkg::REG_VOLUME:    s.volume = val[3:0];
      pvm_pkg::REG_TONE_STEP: s.step = val;
      pvm_pkg::REG_TONE_AMP:  s.amp = val[6:0];
      pvm_pkg::REG_TONE_EN:   s.tone_en = val[0];
      default: ;
    endcase
  endfunction

  // compute one mixed sample and advance every playing voice
  function automatic void mixer_tick(ref mix_state_t s);
    int lvl;
    int sum;
    int smp;
    lvl = 0;
    sum = 0;
    if (s.tone_en) begin
      s.phase = s.phase + s.step;
      lvl = s.phase[15] ? int'(s.amp) : -int'(s.amp);
    end
    for (int v = 0; v < pvm_pkg::VOICES; v++) begin
      if (s.playing[v]) begin
        smp = int'(s.store[s.addr_a[v]]) - 127;
        if (smp > 127) smp -= 256;
        sum += smp;
        s.rem_a[v] = s.rem_a[v] - 1'b1;
        s.addr_a[v] = s.addr_a[v] + 1'b1;
        if (s.rem_a[v] == 0) begin
          if (s.looping[v]) begin
            s.addr_a[v] = s.start_a[v];
            s.rem_a[v] = s.len_a[v];
          end else begin
            s.playing[v] = 0;
          end
        end
      end
    end
    sum = (sum + 2 * lvl) * int'(s.volume);
    if (sum > 127) sum = 127;
    if (sum < -127) sum = -127;
    s.duty = 8'(sum + 127);
  endfunction

  function automatic mix_out_t mixer_apply(ref mix_state_t s, input mix_item_t it);
    mix_out_t r;
    case (it.op)
      pvm_pkg::OP_TICK:  mixer_tick(s);
      pvm_pkg::OP_WRITE: s.store[it.addr] = it.sbyte;
      pvm_pkg::OP_PREPARE: begin
        s.start_a[it.voice] = it.addr; s.addr_a[it.voice] = it.addr;
        s.len_a[it.voice] = it.len; s.rem_a[it.voice] = it.len;
        s.prepared[it.voice] = 1;
      end
      pvm_pkg::OP_PLAY: begin
        if (s.prepared[it.voice]) begin
          s.addr_a[it.voice] = s.start_a[it.voice];
          s.rem_a[it.voice] = s.len_a[it.voice];
          s.playing[it.voice] = 1;
          s.looping[it.voice] = it.loop_m;
        end
      end
      pvm_pkg::OP_STOP: s.playing[it.voice] = 0;
      pvm_pkg::OP_RELEASE: begin
        s.prepared[it.voice] = 0;
        s.playing[it.voice] = 0;
      end
      default: ;
    endcase
    r.duty = s.duty;
    for (int v = 0; v < 8; v++) r.mask[v] = s.playing[v];
    return r;
  endfunction

  function automatic mix_item_t make_item(logic [2:0] op, logic [2:0] voice,
                                          logic [15:0] addr, logic [7:0] sbyte,
                                          logic [16:0] len, logic loop_m);
    mix_item_t it;
    it.op = op; it.voice = voice; it.addr = addr;
    it.sbyte = sbyte; it.len = len; it.loop_m = loop_m;
    return it;
  endfunction

  function automatic mix_item_t rand_item(logic [2:0] op);
    return make_item(op, 3'($urandom), 16'($urandom), 8'($urandom),
                     17'($urandom), 1'($urandom));
  endfunction

  // queue an item; before a tick, stop any voice about to read an unwritten byte
  task automatic queue_item(mix_item_t it);
    mix_out_t unused;
    if (it.op == pvm_pkg::OP_TICK) begin
      for (int v = 0; v < pvm_pkg::VOICES; v++) begin
        if (plan_st.playing[v] && !written[plan_st.addr_a[v]]) begin
          mix_item_t halt;
          halt = rand_item(pvm_pkg::OP_STOP);
          halt.voice = 3'(v);
          unused = mixer_apply(plan_st, halt);
          pending_items.push_back(halt);
        end
      end
    end
    if (it.op == pvm_pkg::OP_WRITE) written[it.addr] = 1;
    unused = mixer_apply(plan_st, it);
    pending_items.push_back(it);
  endtask

  function automatic logic [15:0] region_addr();
    return ($urandom_range(0, 4) == 0) ? 16'($urandom_range(16'hFFE0, 16'hFFFF))
                                       : 16'($urandom_range(0, 255));
  endfunction

  task automatic queue_random(int n);
    mix_item_t it;
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 42) begin
        it = rand_item(pvm_pkg::OP_TICK);
      end else if (pick < 60) begin
        it = rand_item(pvm_pkg::OP_WRITE);
        if ($urandom_range(0, 4) != 0) it.addr = region_addr();
      end else if (pick < 72) begin
        it = rand_item(pvm_pkg::OP_PREPARE);
        if ($urandom_range(0, 4) != 0) begin
          it.addr = region_addr();
          it.len = 17'($urandom_range(1, 40));
        end
      end else if (pick < 86) begin
        it = rand_item(pvm_pkg::OP_PLAY);
      end else if (pick < 92) begin
        it = rand_item(pvm_pkg::OP_STOP);
      end else if (pick < 97) begin
        it = rand_item(pvm_pkg::OP_RELEASE);
      end else begin
        it = rand_item($urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7);
      end
      queue_item(it);
    end
  endtask

  task automatic queue_directed();
    queue_item(make_item(pvm_pkg::OP_WRITE, 3'd0, 16'h0000, 8'hFF, 17'd0, 1'b0));
    queue_item(make_item(pvm_pkg::OP_WRITE, 3'd7, 16'h0001, 8'h00, 17'h1FFFF, 1'b1));
    queue_item(make_item(pvm_pkg::OP_WRITE, 3'd0, 16'h0002, 8'd127, 17'd0, 1'b0));
    queue_item(make_item(pvm_pkg::OP_WRITE, 3'd0, 16'hFFFF, 8'h80, 17'd0, 1'b0));
    queue_item(make_item(pvm_pkg::OP_WRITE, 3'd0, 16'hFFFE, 8'h55, 17'd0, 1'b0));
    queue_item(rand_item(OP_SPARE6));
    queue_item(rand_item(OP_SPARE7));
    // play on a voice that was never prepared
    queue_item(make_item(pvm_pkg::OP_PLAY, 3'd3, 16'h0, 8'h0, 17'd5, 1'b1));
    // address wraps from the top of the store to zero
    queue_item(make_item(pvm_pkg::OP_PREPARE, 3'd0, 16'hFFFE, 8'h0, 17'd4, 1'b0));
    queue_item(make_item(pvm_pkg::OP_PLAY, 3'd0, 16'h0, 8'h0, 17'd0, 1'b0));
    for (int k = 0; k < 5; k++) queue_item(rand_item(pvm_pkg::OP_TICK));
    // zero length wraps the remaining count to the top of the 17-bit range
    queue_item(make_item(pvm_pkg::OP_PREPARE, 3'd7, 16'h0000, 8'h0, 17'd0, 1'b0));
    queue_item(make_item(pvm_pkg::OP_PLAY, 3'd7, 16'h0, 8'h0, 17'd0, 1'b1));
    queue_item(rand_item(pvm_pkg::OP_TICK));
    queue_item(rand_item(pvm_pkg::OP_TICK));
    queue_item(make_item(pvm_pkg::OP_STOP, 3'd7, 16'h0, 8'h0, 17'd0, 1'b0));
    queue_item(make_item(pvm_pkg::OP_PREPARE, 3'd1, 16'h0000, 8'h0, 17'd2, 1'b0));
    queue_item(make_item(pvm_pkg::OP_PLAY, 3'd1, 16'h0, 8'h0, 17'd0, 1'b1));
    for (int k = 0; k < 3; k++) queue_item(rand_item(pvm_pkg::OP_TICK));
    queue_item(make_item(pvm_pkg::OP_RELEASE, 3'd1, 16'h0, 8'h0, 17'd0, 1'b0));
    queue_item(rand_item(pvm_pkg::OP_TICK));
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_outs.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    mixer_config(plan_st, idx, val);
    mixer_config(pred_st, idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // stimulus and phase sequencing
  initial begin
    logic [15:0] cfg_set[5][4];
    cfg_set = '{'{16'd1, 16'h1234, 16'd81, 16'd1},
                '{16'd8, 16'hFFFF, 16'd0, 16'd1},
                '{16'd0, 16'h0007, 16'd127, 16'd1},
                '{16'd15, 16'h8000, 16'd81, 16'd1},
                '{16'd3, 16'h0100, 16'd20, 16'd0}};
    mixer_reset(plan_st);
    mixer_reset(pred_st);
    foreach (written[i]) written[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    queue_directed();
    wait_drained();
    for (int p = 0; p < 5; p++) begin
      for (int r = 0; r < 4; r++) write_reg(2'(r), cfg_set[p][r]);
      queue_random(205);
      wait_drained();
    end
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // input driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    mix_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        it = make_item(in_operation, in_voice, in_address, in_sample_byte,
                       in_length, in_loop_mode);
        expected_outs.push_back(mixer_apply(pred_st, it));
      end
      if (in_valid && !in_ready) begin
        // hold the item until taken
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        in_operation <= it.op;
        in_voice <= it.voice;
        in_address <= it.addr;
        in_sample_byte <= it.sbyte;
        in_length <= it.len;
        in_loop_mode <= it.loop_m;
        if (burst_left == 0) burst_left = $urandom_range(1, 30);
        burst_left--;
        if (burst_left == 0)
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor with its own stall pattern
  int stall_mode = 0;
  int mode_cnt = 0;
  always @(posedge clk) begin
    mix_out_t exp_o;
    if (rst_n && out_valid && out_ready) begin
      if (expected_outs.size() == 0) begin
        $error("unexpected result item: pwm_duty %0d playing_mask %h",
               out_pwm_duty, out_playing_mask);
        failed <= 1'b1;
      end else begin
        exp_o = expected_outs.pop_front();
        if (out_pwm_duty !== exp_o.duty) begin
          $error("pwm_duty expected %0d actual %0d", exp_o.duty, out_pwm_duty);
          failed <= 1'b1;
        end
        if (out_playing_mask !== exp_o.mask) begin
          $error("playing_mask expected %h actual %h", exp_o.mask, out_playing_mask);
          failed <= 1'b1;
        end
      end
    end
    if (mode_cnt == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_cnt = $urandom_range(16, 96);
    end
    mode_cnt--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // watchdog on cycles with no handshake
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
